### hdl/pqdk_pkg.sv
// Package for the priority queue block: command and status codes, field widths,
// parameter defaults and the control/status bundles between controller and datapath.
// No dependencies.
package pqdk_pkg;

  localparam int CAPACITY_DEF  = 32;
  localparam int KEY_WIDTH_DEF = 16;

  localparam int CMD_W    = 3;
  localparam int STAT_W   = 3;
  localparam int KEY_W    = 16;
  localparam int PRIO_W   = 16;
  localparam int ARR_W    = 32;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_DEQUEUE = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_UPGRADE = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STS_OK     = 3'd0,
    STS_EMPTY  = 3'd1,
    STS_NOKEY  = 3'd2,
    STS_HIGHER = 3'd3,
    STS_FULL   = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic sweep_wr;
    logic apply;
    logic out_load;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;
    logic out_busy;
  } stat_t;

endpackage

### hdl/priority_queue_decrease_key_top.sv
// Top level of the min-priority queue with key-based priority lowering.
// Instantiates pqdk_ctrl and pqdk_datapath; depends on pqdk_pkg.
//
// Usage: each command enters on the slave stream channel and produces exactly
// one result on the master stream channel. s_axis_tuser carries the command
// (insert, dequeue, peek, lower priority, clear); s_axis_tdata carries the key
// and the priority. m_axis_tuser carries the status; m_axis_tdata carries the
// key and priority that dequeue or peek found (else zero) and the empty flag.
// Insert, dequeue, peek and lower-priority read the whole slot table, one slot
// per cycle through the single read port of the table memory, and then compute
// their result. Clear writes every slot, one per cycle, before it answers; other
// command codes answer without a table pass. A new command is taken once the
// previous result has entered the output register. After reset the table is
// swept with s_axis_tready low. When the receiver stalls, the result waits in
// the output register and the block takes the next command and works on it
// until its own result is ready.
module priority_queue_decrease_key_top #(
  parameter int CAPACITY  = pqdk_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = pqdk_pkg::KEY_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] entry_key, [31:16] entry_priority
  input  logic [pqdk_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // [2:0] command
  input  logic [pqdk_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] result_key, [31:16] result_priority, [32] now_empty, [39:33] zero
  output logic [pqdk_pkg::M_DATA_W-1:0]     m_axis_tdata,
  // [2:0] status
  output logic [pqdk_pkg::STAT_W-1:0]       m_axis_tuser
);

  pqdk_pkg::ctrl_t ctrl;
  pqdk_pkg::stat_t stat;

  pqdk_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .cmd_i     (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  pqdk_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .cmd_i      (s_axis_tuser),
    .key_i      (s_axis_tdata[pqdk_pkg::KEY_W-1:0]),
    .prio_i     (s_axis_tdata[pqdk_pkg::S_DATA_W-1:pqdk_pkg::KEY_W]),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_status_o (m_axis_tuser),
    .m_data_o   (m_axis_tdata)
  );

endmodule

### hdl/pqdk_ctrl.sv
// Controller state machine of the priority queue: sequences the table scan, the
// clearing sweep, the update and the result transfer. Depends on pqdk_pkg.
module pqdk_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  input  logic [pqdk_pkg::CMD_W-1:0]     cmd_i,
  output logic                           s_ready_o,
  input  pqdk_pkg::stat_t                stat_i,
  output pqdk_pkg::ctrl_t                ctrl_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_SWEEP = 6'b001000,
    ST_APPLY = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   boot_q, boot_d;

  always_comb begin
    state_d = state_q;
    boot_d  = boot_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          ctrl_o.accept = 1'b1;
          unique case (cmd_i) inside
            pqdk_pkg::CMD_CLEAR: state_d = ST_SWEEP;
            pqdk_pkg::CMD_INSERT, pqdk_pkg::CMD_DEQUEUE,
            pqdk_pkg::CMD_PEEK, pqdk_pkg::CMD_UPGRADE: state_d = ST_SCAN;
            default: state_d = ST_APPLY;
          endcase
        end
      end
      ST_SCAN: begin
        ctrl_o.scan_rd = 1'b1;
        if (stat_i.idx_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last read word is evaluated during this cycle.
        state_d = ST_APPLY;
      end
      ST_SWEEP: begin
        ctrl_o.sweep_wr = 1'b1;
        if (stat_i.idx_last) begin
          boot_d  = 1'b0;
          state_d = boot_q ? ST_IDLE : ST_APPLY;
        end
      end
      ST_APPLY: begin
        ctrl_o.apply = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_ready_o = (state_q == ST_IDLE);

  // After reset the table is swept clean before the first transfer is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      boot_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      boot_q  <= boot_d;
    end
  end

endmodule

### hdl/pqdk_datapath.sv
// Datapath of the priority queue: slot table memory, scan index, best-candidate
// registers, occupancy and arrival counters, result and output registers.
// Depends on pqdk_pkg.
module pqdk_datapath #(
  parameter int CAPACITY  = pqdk_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = pqdk_pkg::KEY_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pqdk_pkg::ctrl_t                   ctrl_i,
  output pqdk_pkg::stat_t                   stat_o,
  input  logic [pqdk_pkg::CMD_W-1:0]        cmd_i,
  input  logic [pqdk_pkg::KEY_W-1:0]        key_i,
  input  logic [pqdk_pkg::PRIO_W-1:0]       prio_i,
  input  logic                              m_ready_i,
  output logic                              m_valid_o,
  output logic [pqdk_pkg::STAT_W-1:0]       m_status_o,
  output logic [pqdk_pkg::M_DATA_W-1:0]     m_data_o
);

  localparam int SKW = (KEY_WIDTH < pqdk_pkg::KEY_W) ? KEY_WIDTH : pqdk_pkg::KEY_W;
  localparam int IW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = pqdk_pkg::PRIO_W;
  localparam int AW  = pqdk_pkg::ARR_W;
  localparam int SW  = pqdk_pkg::STAT_W;
  localparam int PADW = pqdk_pkg::M_DATA_W - 2 * pqdk_pkg::KEY_W - 1;

  // Slot table.
  logic           mem_vld  [CAPACITY];
  logic [SKW-1:0] mem_key  [CAPACITY];
  logic [PW-1:0]  mem_prio [CAPACITY];
  logic [AW-1:0]  mem_arr  [CAPACITY];

  logic           rd_vld_bit_q;
  logic [SKW-1:0] rd_key_q;
  logic [PW-1:0]  rd_prio_q;
  logic [AW-1:0]  rd_arr_q;

  logic           we;
  logic [IW-1:0]  waddr;
  logic           wvld;
  logic [SKW-1:0] wkey;
  logic [PW-1:0]  wprio;
  logic [AW-1:0]  warr;

  // Command capture.
  logic [pqdk_pkg::CMD_W-1:0] cmd_q;
  logic [SKW-1:0]             key_q;
  logic [PW-1:0]              prio_q;

  // Scan control.
  logic [IW-1:0] idx_q;
  logic          rd_vld_q;
  logic [IW-1:0] rd_idx_q;

  // Best candidate of the current scan.
  logic           found_q;
  logic [IW-1:0]  best_idx_q;
  logic [SKW-1:0] best_key_q;
  logic [PW-1:0]  best_prio_q;
  logic [AW-1:0]  best_arr_q;
  logic           beats;
  logic           take;

  logic [CW-1:0] occ_q, occ_d;
  logic [AW-1:0] arr_q, arr_d;

  logic [SW-1:0] sts_d;
  logic [SKW-1:0] rkey_d;
  logic [PW-1:0] rprio_d;

  logic [SW-1:0] res_status_q;
  logic [SKW-1:0] res_key_q;
  logic [PW-1:0] res_prio_q;
  logic          res_empty_q;

  logic          m_valid_q;
  logic [SW-1:0] m_status_q;
  logic [SKW-1:0] m_key_q;
  logic [PW-1:0] m_prio_q;
  logic          m_empty_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_vld[waddr]  <= wvld;
      mem_key[waddr]  <= wkey;
      mem_prio[waddr] <= wprio;
      mem_arr[waddr]  <= warr;
    end
    rd_vld_bit_q <= mem_vld[idx_q];
    rd_key_q     <= mem_key[idx_q];
    rd_prio_q    <= mem_prio[idx_q];
    rd_arr_q     <= mem_arr[idx_q];
  end

  assign stat_o.idx_last = (idx_q == IW'(CAPACITY - 1));
  assign stat_o.out_busy = m_valid_q && !m_ready_i;

  // Lower priority wins; equal priority goes to the earlier stamp.
  assign beats = (rd_prio_q < best_prio_q) ||
                 ((rd_prio_q == best_prio_q) && (rd_arr_q < best_arr_q));

  always_comb begin
    take = 1'b0;
    if (rd_vld_q) begin
      case (cmd_q) inside
        pqdk_pkg::CMD_INSERT:  take = !found_q && !rd_vld_bit_q;
        pqdk_pkg::CMD_DEQUEUE,
        pqdk_pkg::CMD_PEEK:    take = rd_vld_bit_q && (!found_q || beats);
        pqdk_pkg::CMD_UPGRADE: take = rd_vld_bit_q && (rd_key_q == key_q) &&
                                      (!found_q || beats);
        default:               take = 1'b0;
      endcase
    end
  end

  always_comb begin
    we      = 1'b0;
    waddr   = idx_q;
    wvld    = 1'b0;
    wkey    = '0;
    wprio   = '0;
    warr    = '0;
    occ_d   = occ_q;
    arr_d   = arr_q;
    sts_d   = pqdk_pkg::STS_OK;
    rkey_d  = '0;
    rprio_d = '0;
    if (ctrl_i.sweep_wr) begin
      we = 1'b1;
    end
    if (ctrl_i.apply) begin
      case (cmd_q) inside
        pqdk_pkg::CMD_INSERT: begin
          if (occ_q == CW'(CAPACITY)) begin
            sts_d = pqdk_pkg::STS_FULL;
          end else begin
            we    = 1'b1;
            waddr = best_idx_q;
            wvld  = 1'b1;
            wkey  = key_q;
            wprio = prio_q;
            warr  = arr_q;
            occ_d = occ_q + CW'(1);
            arr_d = arr_q + AW'(1);
          end
        end
        pqdk_pkg::CMD_DEQUEUE, pqdk_pkg::CMD_PEEK: begin
          if (!found_q) begin
            sts_d = pqdk_pkg::STS_EMPTY;
          end else begin
            rkey_d  = best_key_q;
            rprio_d = best_prio_q;
            if (cmd_q == pqdk_pkg::CMD_DEQUEUE) begin
              we    = 1'b1;
              waddr = best_idx_q;
              wkey  = best_key_q;
              wprio = best_prio_q;
              warr  = best_arr_q;
              occ_d = occ_q - CW'(1);
            end
          end
        end
        pqdk_pkg::CMD_UPGRADE: begin
          if (occ_q == '0) begin
            sts_d = pqdk_pkg::STS_EMPTY;
          end else if (!found_q) begin
            sts_d = pqdk_pkg::STS_NOKEY;
          end else if (best_prio_q < prio_q) begin
            sts_d = pqdk_pkg::STS_HIGHER;
          end else begin
            we    = 1'b1;
            waddr = best_idx_q;
            wvld  = 1'b1;
            wkey  = best_key_q;
            wprio = prio_q;
            warr  = best_arr_q;
          end
        end
        pqdk_pkg::CMD_CLEAR: occ_d = '0;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q  <= cmd_i;
      key_q  <= key_i[SKW-1:0];
      prio_q <= prio_i;
    end
    if (take) begin
      best_idx_q  <= rd_idx_q;
      best_key_q  <= rd_key_q;
      best_prio_q <= rd_prio_q;
      best_arr_q  <= rd_arr_q;
    end
    if (ctrl_i.apply) begin
      res_status_q <= sts_d;
      res_key_q    <= rkey_d;
      res_prio_q   <= rprio_d;
      res_empty_q  <= (occ_d == '0);
    end
    if (ctrl_i.out_load) begin
      m_status_q <= res_status_q;
      m_key_q    <= res_key_q;
      m_prio_q   <= res_prio_q;
      m_empty_q  <= res_empty_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      found_q   <= 1'b0;
      occ_q     <= '0;
      arr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.accept) begin
        idx_q <= '0;
      end else if (ctrl_i.scan_rd || ctrl_i.sweep_wr) begin
        idx_q <= stat_o.idx_last ? '0 : idx_q + IW'(1);
      end
      rd_vld_q <= ctrl_i.scan_rd;
      rd_idx_q <= idx_q;
      if (ctrl_i.accept) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
      occ_q <= occ_d;
      arr_q <= arr_d;
      if (ctrl_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o  = m_valid_q;
  assign m_status_o = m_status_q;
  assign m_data_o   = {PADW'(0), m_empty_q, m_prio_q, pqdk_pkg::KEY_W'(m_key_q)};

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(CAPACITY))
    else $error("occupancy exceeds capacity");

  a_deq_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.apply && cmd_q == pqdk_pkg::CMD_DEQUEUE && found_q)
      |=> occ_q == $past(occ_q) - CW'(1))
    else $error("dequeue of a found entry did not free a slot");

  a_ins_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.apply && cmd_q == pqdk_pkg::CMD_INSERT && occ_q != CW'(CAPACITY))
      |=> arr_q == $past(arr_q) + AW'(1))
    else $error("insert did not advance the arrival stamp");

  a_ins_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.apply && cmd_q == pqdk_pkg::CMD_INSERT && occ_q != CW'(CAPACITY))
      |-> found_q)
    else $error("insert into a table with room found no free slot");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |-> !(m_valid_q && !m_ready_i))
    else $error("result loaded over a pending transfer");
`endif

endmodule
